// ===== src/hrdp_pkg.sv =====
// Shared types, codes and helpers for the HID report descriptor item parser.
// No dependencies; every other file of the block imports this package.
package hrdp_pkg;

	// Collection depth limit and counter width
	localparam int MAX_DEPTH = 15;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int NEST_W    = 4;

	// Item queue between the byte front end and the depth back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Prefix byte fields
	localparam logic [7:0] PFX_SIZE_MASK = 8'h03;
	localparam logic [7:0] PFX_TYPE_MASK = 8'h0C;
	localparam logic [7:0] PFX_TAG_MASK  = 8'hF0;

	// Main item tags
	localparam logic [3:0] TAG_INPUT          = 4'h8;
	localparam logic [3:0] TAG_OUTPUT         = 4'h9;
	localparam logic [3:0] TAG_COLLECTION     = 4'hA;
	localparam logic [3:0] TAG_FEATURE        = 4'hB;
	localparam logic [3:0] TAG_END_COLLECTION = 4'hC;

	// Highest known global tag, known local tag ranges
	localparam logic [3:0] TAG_GLOBAL_LAST = 4'hB;
	localparam logic [3:0] TAG_LOCAL_LAST0 = 4'h5;
	localparam logic [3:0] TAG_LOCAL_FIRST1 = 4'h7;
	localparam logic [3:0] TAG_LOCAL_LAST1 = 4'hA;

	// Collection kind codes
	localparam logic [31:0] KIND_LAST_DEFINED = 32'd6;
	localparam logic [2:0]  KIND_RESERVED     = 3'd7;
	localparam logic [2:0]  KIND_NONE         = 3'd0;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_MAIN   = 3'd1,
		ST_BAD_GLOBAL = 3'd2,
		ST_BAD_LOCAL  = 3'd3,
		ST_LONG       = 3'd4,
		ST_UNDERFLOW  = 3'd5,
		ST_OVERFLOW   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		TYPE_MAIN   = 2'd0,
		TYPE_GLOBAL = 2'd1,
		TYPE_LOCAL  = 2'd2,
		TYPE_LONG   = 2'd3
	} item_type_t;

	// Item as classified by the front end
	typedef struct packed {
		status_t     status;
		item_type_t  item_type;
		logic [3:0]  tag;
		logic [2:0]  size;
		logic [31:0] value;
	} hrdp_item_t;

	// Finished result as held in the output register
	typedef struct packed {
		status_t           status;
		item_type_t        item_type;
		logic [3:0]        tag;
		logic [2:0]        size;
		logic [31:0]       value;
		logic [NEST_W-1:0] nest;
		logic [2:0]        kind;
		logic              closed;
	} hrdp_result_t;

	// Size code 0..3 to byte count 0, 1, 2, 4
	function automatic logic [2:0] size_of_code(input logic [1:0] code);
		logic [2:0] n;
		n = (code == 2'd3) ? 3'd4 : {1'b0, code};
		return n;
	endfunction

	// Check a short item tag against its type
	function automatic logic tag_known(input item_type_t t, input logic [3:0] tag);
		logic ok;
		case (t)
			TYPE_MAIN: begin
				ok = (tag == TAG_INPUT) || (tag == TAG_OUTPUT) || (tag == TAG_COLLECTION)
					|| (tag == TAG_FEATURE) || (tag == TAG_END_COLLECTION);
			end
			TYPE_GLOBAL: begin
				ok = (tag <= TAG_GLOBAL_LAST);
			end
			TYPE_LOCAL: begin
				ok = (tag <= TAG_LOCAL_LAST0)
					|| ((tag >= TAG_LOCAL_FIRST1) && (tag <= TAG_LOCAL_LAST1));
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		return ok;
	endfunction

	// Error code for an unknown tag of a given type
	function automatic status_t bad_tag_status(input item_type_t t);
		status_t s;
		case (t)
			TYPE_MAIN:   s = ST_BAD_MAIN;
			TYPE_GLOBAL: s = ST_BAD_GLOBAL;
			TYPE_LOCAL:  s = ST_BAD_LOCAL;
			default:     s = ST_LONG;
		endcase
		return s;
	endfunction

endpackage

// ===== src/hrdp_front.sv =====
// Byte front end: decodes prefix bytes, gathers data bytes, flags bad tags
// and long items. Depends on hrdp_pkg.
module hrdp_front
	import hrdp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] descriptor_byte,
	input  logic       q_full,
	output logic       q_push,
	output hrdp_item_t q_item
);

	logic [2:0]  left_q;
	logic [7:0]  prefix_q;
	logic [31:0] accum_q;
	logic [1:0]  taken_q;
	logic        halted_q;

	logic        accept;
	item_type_t  b_type;
	logic [3:0]  b_tag;
	logic [2:0]  b_size;
	logic [31:0] new_accum;

	// Take a byte whenever the queue has room; drop bytes once halted
	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready && !halted_q;

	// Decode the byte as a prefix
	assign b_type = item_type_t'((descriptor_byte & PFX_TYPE_MASK) >> 2);
	assign b_tag  = 4'((descriptor_byte & PFX_TAG_MASK) >> 4);
	assign b_size = size_of_code(descriptor_byte[1:0] & PFX_SIZE_MASK[1:0]);

	// Merge the byte into the little-endian value
	assign new_accum = accum_q | ({24'b0, descriptor_byte} << {taken_q, 3'b000});

	// Build the item record and decide on a push
	always_comb begin
		q_push = 1'b0;
		q_item = '{status: ST_OK, item_type: b_type, tag: b_tag, size: b_size,
			value: 32'd0};
		if (accept) begin
			if (left_q == 3'd0) begin
				if (b_type == TYPE_LONG) begin
					q_push         = 1'b1;
					q_item.status    = ST_LONG;
					q_item.item_type = TYPE_MAIN;
				end else if (!tag_known(b_type, b_tag)) begin
					q_push        = 1'b1;
					q_item.status = bad_tag_status(b_type);
				end else if (b_size == 3'd0) begin
					q_push = 1'b1;
				end
			end else begin
				q_item.item_type = item_type_t'((prefix_q & PFX_TYPE_MASK) >> 2);
				q_item.tag       = 4'((prefix_q & PFX_TAG_MASK) >> 4);
				q_item.size      = size_of_code(prefix_q[1:0]);
				q_item.value     = new_accum;
				q_push           = (left_q == 3'd1);
			end
		end
	end

	// Advance the byte counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 3'd0;
			taken_q  <= 2'd0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (left_q == 3'd0) begin
				taken_q <= 2'd0;
				if (b_type == TYPE_LONG || !tag_known(b_type, b_tag)) begin
					halted_q <= 1'b1;
				end else begin
					left_q <= b_size;
				end
			end else begin
				left_q  <= left_q - 3'd1;
				taken_q <= (left_q == 3'd1) ? 2'd0 : taken_q + 2'd1;
			end
		end
	end

	// Hold the prefix and the gathered bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			if (left_q == 3'd0) begin
				prefix_q <= descriptor_byte;
				accum_q  <= 32'd0;
			end else begin
				accum_q <= new_accum;
			end
		end
	end

endmodule

// ===== src/hrdp_queue.sv =====
// Short item queue between the front end and the back end.
// Depends on hrdp_pkg for the item record and depth.
module hrdp_queue
	import hrdp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hrdp_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       pop_valid,
	output hrdp_item_t pop_item
);

	hrdp_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Store an entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/hrdp_back.sv =====
// Back end: tracks collection depth, checks underflow and overflow, and
// holds the result register. Depends on hrdp_pkg.
module hrdp_back
	import hrdp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  hrdp_item_t   q_item,
	output logic         q_pop,
	output logic         result_valid,
	input  logic         result_ready,
	output hrdp_result_t result,
	output logic         halted
);

	logic [DEPTH_W-1:0] depth_q;
	logic               halted_q;
	logic               valid_q;
	hrdp_result_t       res_q;

	logic               load;
	logic               is_coll;
	logic               is_end;
	hrdp_result_t       res_d;
	logic [DEPTH_W-1:0] depth_d;
	logic               halt_d;

	// Pop when the result register frees up; drain and drop once halted
	assign q_pop = q_valid && (halted_q || !valid_q || result_ready);
	assign load  = q_pop && !halted_q;

	assign is_coll = (q_item.status == ST_OK) && (q_item.item_type == TYPE_MAIN)
		&& (q_item.tag == TAG_COLLECTION);
	assign is_end  = (q_item.status == ST_OK) && (q_item.item_type == TYPE_MAIN)
		&& (q_item.tag == TAG_END_COLLECTION);

	// Apply the item to the depth counter and form the result
	always_comb begin
		depth_d = depth_q;
		halt_d  = (q_item.status != ST_OK);
		res_d   = '{status: q_item.status, item_type: q_item.item_type,
			tag: q_item.tag, size: q_item.size, value: q_item.value,
			nest: NEST_W'(depth_q), kind: KIND_NONE, closed: 1'b0};
		if (is_coll) begin
			res_d.kind = (q_item.value <= KIND_LAST_DEFINED) ? q_item.value[2:0]
				: KIND_RESERVED;
			if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
				res_d.status = ST_OVERFLOW;
				depth_d      = DEPTH_W'(MAX_DEPTH);
				res_d.nest   = NEST_W'(DEPTH_W'(MAX_DEPTH));
				halt_d       = 1'b1;
			end else begin
				depth_d = depth_q + DEPTH_W'(1);
			end
		end else if (is_end) begin
			if (depth_q == '0) begin
				res_d.status = ST_UNDERFLOW;
				halt_d       = 1'b1;
			end else begin
				depth_d      = depth_q - DEPTH_W'(1);
				res_d.nest   = NEST_W'(depth_d);
				res_d.closed = (depth_d == '0);
			end
		end
	end

	// Control state: depth, halt and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			halted_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				depth_q  <= depth_d;
				halted_q <= halt_d;
				valid_q  <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;
	assign halted       = halted_q;

endmodule

// ===== src/hid_report_descriptor_item_parser_unit.sv =====
// Top level of the HID report descriptor short item parser: front end,
// item queue and back end. Depends on hrdp_pkg, hrdp_front, hrdp_queue, hrdp_back.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_ready      descriptor_byte
//   result    out        result_valid / result_ready  status .. top_closed
//
// One descriptor byte per cycle while byte_ready is high; a complete item's result
// goes from the front end into the queue, then into the result register.
// The result register pops the queue in the same cycle its result is taken.
// A stalled result side fills the four-entry queue, then byte_ready drops.
// Reset is asynchronous and clears depth, counters, queue and halt state.
// After an error result all further bytes are taken and dropped until reset.
module hid_report_descriptor_item_parser_unit
	import hrdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  descriptor_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [1:0]  item_type,
	output logic [3:0]  item_tag,
	output logic [2:0]  data_size,
	output logic [31:0] data_value,
	output logic [3:0]  nest_depth,
	output logic [2:0]  collection_kind,
	output logic        top_closed
);

	logic         q_push;
	logic         q_full;
	logic         q_pop;
	logic         q_valid;
	hrdp_item_t   push_item;
	hrdp_item_t   pop_item;
	hrdp_result_t result;
	logic         back_halted;

	hrdp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_ready      (byte_ready),
		.descriptor_byte (descriptor_byte),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (push_item)
	);

	hrdp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (pop_item)
	);

	hrdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.halted       (back_halted)
	);

	// Unpack the result register onto the ports
	assign status          = result.status;
	assign item_type       = result.item_type;
	assign item_tag        = result.tag;
	assign data_size       = result.size;
	assign data_value      = result.value;
	assign nest_depth      = result.nest;
	assign collection_kind = result.kind;
	assign top_closed      = result.closed;

`ifndef SYNTHESIS
	// The front end never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("item pushed into full queue");

	// Once halted, the back end stays halted
	assert property (@(posedge clk) disable iff (!arst_n) back_halted |=> back_halted)
		else $error("halt released without reset");

	// A shown error result means the back end has halted
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status != ST_OK)) |-> back_halted)
		else $error("error result without halt");

	// Closing the top level always lands at depth zero with an ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && top_closed) |-> ((nest_depth == '0) && (status == ST_OK)))
		else $error("top closed at nonzero depth");
`endif

endmodule
